// File: src/length_framed_bit_receiver_crc8_unit_defines.svh
// Assertion macros shared by the length-framed bit receiver RTL.
`ifndef LENGTH_FRAMED_BIT_RECEIVER_CRC8_UNIT_DEFINES_SVH
`define LENGTH_FRAMED_BIT_RECEIVER_CRC8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset.
`define LFBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// Check that a condition never occurs outside reset.
`define LFBR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);
`else
`define LFBR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFBR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: src/lfbr_pkg.sv
// Shared types, constants and the CRC-8 byte fold for the bit receiver.
package lfbr_pkg;

    localparam int BYTE_W            = 8;
    localparam int BIT_CNT_W         = $clog2(BYTE_W);
    localparam int HEADER_SKIP_BYTES = 5;
    localparam int LENGTH_END_BIT    = 32;
    localparam int LEN_END_BYTES     = LENGTH_END_BIT / BYTE_W;
    localparam int LEN_BYTE_IDX      = LEN_END_BYTES - 1;

    localparam logic [BYTE_W-1:0]    CRC_POLY_RESET = 8'd7;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT_POS   = BIT_CNT_W'(BYTE_W - 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_item;

    // MSB-first CRC-8 update of one byte, implicit x^8 term.
    function automatic logic [BYTE_W-1:0] crc_fold(
        input logic [BYTE_W-1:0] rem,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] r;
        r = rem ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[BYTE_W-1]) begin
                r = {r[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                r = {r[BYTE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// File: src/lfbr_front.sv
// Front end: gathers line bits MSB first and pushes each finished byte.
module lfbr_front
    import lfbr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_line_bit,
    input  logic       i_q_full,
    output logic       o_ready,
    output t_byte_item o_push
);

    logic [BYTE_W-2:0]    r_shift;
    logic [BYTE_W-2:0]    n_shift;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [BIT_CNT_W-1:0] n_bit_cnt;
    logic                 w_accept;

    // Stall only the bit that would complete a byte into a full queue.
    assign o_ready  = !(i_q_full && (r_bit_cnt == LAST_BIT_POS));
    assign w_accept = i_valid && o_ready;

    assign o_push.valid = w_accept && (r_bit_cnt == LAST_BIT_POS);
    assign o_push.data  = {r_shift, i_line_bit};

    always_comb begin
        n_shift   = r_shift;
        n_bit_cnt = r_bit_cnt;
        if (w_accept) begin
            n_shift   = {r_shift[BYTE_W-3:0], i_line_bit};
            n_bit_cnt = r_bit_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
        end else begin
            r_bit_cnt <= n_bit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

endmodule

// File: src/lfbr_queue.sv
// Two-entry byte queue between the bit gatherer and the frame logic.
`include "length_framed_bit_receiver_crc8_unit_defines.svh"
module lfbr_queue
    import lfbr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_byte_item i_push,
    input  logic       i_pop,
    output t_byte_item o_head,
    output logic       o_full
);

    logic [BYTE_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    `LFBR_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push.valid && o_full, "queue overflow")
    `LFBR_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == '0), "queue underflow")
    `LFBR_ASSERT(a_pop_drains, i_clk, i_rst_n, (i_pop && !i_push.valid) |=> (r_count == $past(r_count) - 1'b1), "queue count did not drop on pop")

endmodule

// File: src/lfbr_back.sv
// Back end: byte framing, length capture, CRC-8 check and output register.
`include "length_framed_bit_receiver_crc8_unit_defines.svh"
module lfbr_back
    import lfbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_byte_item        i_head,
    input  logic [BYTE_W-1:0] i_crc_poly,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte_value,
    output logic              o_frame_end,
    output logic              o_crc_ok
);

    logic [BYTE_W-1:0] r_byte_idx;
    logic [BYTE_W-1:0] r_frame_len;
    logic [BYTE_W-1:0] r_crc;
    logic [BYTE_W-1:0] n_byte_idx;
    logic [BYTE_W-1:0] n_frame_len;
    logic [BYTE_W-1:0] n_crc;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_end;
    logic              r_out_ok;

    logic              w_is_len;
    logic              w_short;
    logic              w_exact;
    logic              w_crc_match;
    logic              w_last;
    logic              w_ok;
    logic              w_fold;
    logic [BYTE_W:0]   w_idx_next;

    // Take the next byte when the output register is free or being drained.
    assign o_pop = i_head.valid && (!r_out_valid || i_ready);

    assign w_is_len    = (r_byte_idx == BYTE_W'(LEN_BYTE_IDX));
    assign w_short     = (i_head.data < BYTE_W'(LEN_END_BYTES));
    assign w_exact     = (i_head.data == BYTE_W'(LEN_END_BYTES));
    assign w_crc_match = (r_crc == i_head.data);
    assign w_idx_next  = {1'b0, r_byte_idx} + 1'b1;

    always_comb begin
        if (w_is_len) begin
            w_last = w_short || w_exact;
            w_ok   = w_exact && w_crc_match;
        end else begin
            w_last = (r_byte_idx > BYTE_W'(LEN_BYTE_IDX))
                  && (w_idx_next == {1'b0, r_frame_len});
            w_ok   = w_crc_match;
        end
    end

    assign w_fold = !w_last && (r_byte_idx >= BYTE_W'(HEADER_SKIP_BYTES));

    always_comb begin
        n_byte_idx  = r_byte_idx;
        n_frame_len = r_frame_len;
        n_crc       = r_crc;
        if (o_pop) begin
            if (w_last) begin
                n_byte_idx  = '0;
                n_frame_len = '0;
                n_crc       = '0;
            end else begin
                n_byte_idx = w_idx_next[BYTE_W-1:0];
                if (w_is_len) begin
                    n_frame_len = i_head.data;
                end
                if (w_fold) begin
                    n_crc = crc_fold(r_crc, i_head.data, i_crc_poly);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx  <= '0;
            r_frame_len <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_idx  <= n_byte_idx;
            r_frame_len <= n_frame_len;
            r_crc       <= n_crc;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_byte <= i_head.data;
            r_out_end  <= w_last;
            r_out_ok   <= w_last && w_ok;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte_value = r_out_byte;
    assign o_frame_end  = r_out_end;
    assign o_crc_ok     = r_out_ok;

    `LFBR_ASSERT(a_ok_needs_end, i_clk, i_rst_n, (r_out_valid && r_out_ok) |-> r_out_end, "crc_ok without frame_end")
    `LFBR_ASSERT(a_end_restarts, i_clk, i_rst_n, (o_pop && w_last) |=> ((r_byte_idx == '0) && (r_crc == '0)), "frame state not cleared at frame end")
    `LFBR_ASSERT(a_len_bounds_idx, i_clk, i_rst_n, (r_frame_len != '0) |-> (r_byte_idx < r_frame_len), "byte index ran past frame length")

endmodule

// File: src/length_framed_bit_receiver_crc8_unit.sv
// Top level of the length-framed bit receiver with CRC-8 check.
//   Input channel (i_valid / o_ready / i_line_bit) takes one sampled line
//   bit per item, most significant bit of each byte first. One item can be
//   accepted every cycle while o_ready is high.
//   Output channel (o_valid / i_ready) delivers one item per completed byte:
//   o_byte_value, o_frame_end on the last byte of a frame, and o_crc_ok on
//   that last byte when the CRC-8 over bytes 5 through length-2 matches it.
//   Byte 3 of each frame is the frame length in bytes; a length of 4 or
//   less ends the frame at byte 3 with o_crc_ok low.
//   A finished byte passes through the queue and then the output register
//   before it is presented on the output; a stalled output register holds
//   it back. The output register can take a new byte while handing one off.
//   i_cfg_wr_en / i_cfg_wr_data write the CRC polynomial (x^8 implicit);
//   write only while the block is idle.
//   Reset (synchronous, active low) clears the frame state, empties the
//   queue, drops any pending result and restores polynomial 0x07.
//   When the receiver stalls, the output register holds its item, the
//   two-byte queue fills, and o_ready falls only for a bit that would
//   complete a byte with the queue full.
module length_framed_bit_receiver_crc8_unit
    import lfbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_line_bit,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte_value,
    output logic              o_frame_end,
    output logic              o_crc_ok,
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data
);

    logic [BYTE_W-1:0] r_crc_poly;
    t_byte_item        w_push;
    t_byte_item        w_head;
    logic              w_q_full;
    logic              w_pop;

    // Hold the polynomial; a write takes effect on the next byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= CRC_POLY_RESET;
        end else if (i_cfg_wr_en) begin
            r_crc_poly <= i_cfg_wr_data;
        end
    end

    // Gather bits into bytes.
    lfbr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_line_bit (i_line_bit),
        .i_q_full   (w_q_full),
        .o_ready    (o_ready),
        .o_push     (w_push)
    );

    // Decouple the bit side from the frame side.
    lfbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full)
    );

    // Frame, check and register each byte for the output channel.
    lfbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_crc_poly   (r_crc_poly),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte_value (o_byte_value),
        .o_frame_end  (o_frame_end),
        .o_crc_ok     (o_crc_ok)
    );

endmodule
